// ===== rtl/tfss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the flat-triangle split setup.
// No dependencies; used by every module of the block.
package tfss_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int COLOR_WIDTH = 16;

   // quotient bits of the split divider, enough for both the x and the color cut
   localparam int DIV_STEPS   = (COORD_WIDTH > COLOR_WIDTH) ? COORD_WIDTH : COLOR_WIDTH;
   localparam int NUM_WIDTH   = COORD_WIDTH + DIV_STEPS;
   localparam int XSUM_WIDTH  = 2 * COORD_WIDTH + 1;
   localparam int CSUM_WIDTH  = COORD_WIDTH + COLOR_WIDTH;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic        [COLOR_WIDTH-1:0] c;
   } vtx_type;

   typedef struct packed {
      vtx_type p1;
      vtx_type p2;
      vtx_type p3;
      logic    flat_top;
      logic    flat_bot;
      logic    drop;
   } geo_type;

   // divider work word: remainder in the high bits, numerator/quotient in the low bits
   typedef struct packed {
      geo_type                geo;
      logic [COORD_WIDTH-1:0] den;
      logic                   xneg;
      logic [NUM_WIDTH-1:0]   xrq;
      logic [NUM_WIDTH-1:0]   crq;
   } div_work_type;

endpackage

// ===== rtl/tfss_sort.sv =====
`timescale 1ns / 1ps
// Two-stage vertex sort by y with strict compare-exchange, plus case flags.
// Depends on tfss_pkg.
module tfss_sort (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tfss_pkg::vtx_type in_a,
   input  tfss_pkg::vtx_type in_b,
   input  tfss_pkg::vtx_type in_c,
   output logic             out_valid,
   input  logic             out_ready,
   output tfss_pkg::geo_type out_geo
);
   import tfss_pkg::*;

   logic    s1_vld_ff;
   vtx_type s1_lo_ff, s1_mid_ff, s1_hi_ff;
   vtx_type s1_lo_in, s1_mid_in, s1_hi_in;
   vtx_type ab_lo, ab_hi;
   logic    s2_vld_ff;
   geo_type s2_geo_ff, s2_geo_in;
   logic    en1, en2;

   assign en2      = !s2_vld_ff || out_ready;
   assign en1      = !s1_vld_ff || en2;
   assign in_ready = en1;

   // first and second, then first and third
   always_comb begin
      if ($signed(in_a.y) > $signed(in_b.y)) begin
         ab_lo = in_b;
         ab_hi = in_a;
      end else begin
         ab_lo = in_a;
         ab_hi = in_b;
      end
      s1_mid_in = ab_hi;
      if ($signed(ab_lo.y) > $signed(in_c.y)) begin
         s1_lo_in = in_c;
         s1_hi_in = ab_lo;
      end else begin
         s1_lo_in = ab_lo;
         s1_hi_in = in_c;
      end
   end

   // second and third, then classify
   always_comb begin
      s2_geo_in.p1 = s1_lo_ff;
      if ($signed(s1_mid_ff.y) > $signed(s1_hi_ff.y)) begin
         s2_geo_in.p2 = s1_hi_ff;
         s2_geo_in.p3 = s1_mid_ff;
      end else begin
         s2_geo_in.p2 = s1_mid_ff;
         s2_geo_in.p3 = s1_hi_ff;
      end
      s2_geo_in.flat_top = (s2_geo_in.p1.y == s2_geo_in.p2.y);
      s2_geo_in.flat_bot = (s2_geo_in.p2.y == s2_geo_in.p3.y);
      s2_geo_in.drop     = (s2_geo_in.p1.y == s2_geo_in.p3.y) ||
                           ((s2_geo_in.p1.x == s2_geo_in.p2.x) &&
                            (s2_geo_in.p2.x == s2_geo_in.p3.x));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (en1) s1_vld_ff <= in_valid;
         if (en2) s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_lo_ff  <= s1_lo_in;
         s1_mid_ff <= s1_mid_in;
         s1_hi_ff  <= s1_hi_in;
      end
      if (en2) s2_geo_ff <= s2_geo_in;
   end

   assign out_valid = s2_vld_ff;
   assign out_geo   = s2_geo_ff;

endmodule

// ===== rtl/tfss_interp.sv =====
`timescale 1ns / 1ps
// Four-stage setup of the split interpolation: weights, products, sums, magnitude.
// Depends on tfss_pkg; feeds tfss_div.
module tfss_interp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tfss_pkg::geo_type      in_geo,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tfss_pkg::div_work_type out_data
);
   import tfss_pkg::*;

   logic [3:0] vld_ff;
   logic [4:0] en;

   geo_type                a_geo_ff;
   logic [COORD_WIDTH-1:0] a_w1_ff, a_w3_ff, a_den_ff;
   logic [COORD_WIDTH-1:0] a_w1_in, a_w3_in, a_den_in;

   geo_type                 b_geo_ff;
   logic [COORD_WIDTH-1:0]  b_den_ff;
   logic signed [XSUM_WIDTH-1:0] b_px1_ff, b_px3_ff, b_px1_in, b_px3_in;
   logic [CSUM_WIDTH-1:0]   b_pc1_ff, b_pc3_ff, b_pc1_in, b_pc3_in;

   geo_type                 c_geo_ff;
   logic [COORD_WIDTH-1:0]  c_den_ff;
   logic signed [XSUM_WIDTH-1:0] c_sx_ff, c_sx_in;
   logic [CSUM_WIDTH-1:0]   c_sc_ff, c_sc_in;

   div_work_type            d_data_ff, d_data_in;
   logic [XSUM_WIDTH-1:0]   xmag;

   assign en[4] = out_ready;
   assign en[3] = !vld_ff[3] || en[4];
   assign en[2] = !vld_ff[2] || en[3];
   assign en[1] = !vld_ff[1] || en[2];
   assign en[0] = !vld_ff[0] || en[1];
   assign in_ready = en[0];

   always_comb begin
      a_w1_in  = in_geo.p3.y - in_geo.p2.y;
      a_w3_in  = in_geo.p2.y - in_geo.p1.y;
      a_den_in = in_geo.p3.y - in_geo.p1.y;
   end

   always_comb begin
      b_px1_in = XSUM_WIDTH'($signed({1'b0, a_w1_ff})) * XSUM_WIDTH'(a_geo_ff.p1.x);
      b_px3_in = XSUM_WIDTH'($signed({1'b0, a_w3_ff})) * XSUM_WIDTH'(a_geo_ff.p3.x);
      b_pc1_in = CSUM_WIDTH'(a_w1_ff) * CSUM_WIDTH'(a_geo_ff.p1.c);
      b_pc3_in = CSUM_WIDTH'(a_w3_ff) * CSUM_WIDTH'(a_geo_ff.p3.c);
   end

   always_comb begin
      c_sx_in = b_px1_ff + b_px3_ff;
      c_sc_in = b_pc1_ff + b_pc3_ff;
   end

   always_comb begin
      xmag           = c_sx_ff[XSUM_WIDTH-1] ? XSUM_WIDTH'(-c_sx_ff) : XSUM_WIDTH'(c_sx_ff);
      d_data_in.geo  = c_geo_ff;
      d_data_in.den  = c_den_ff;
      d_data_in.xneg = c_sx_ff[XSUM_WIDTH-1];
      d_data_in.xrq  = NUM_WIDTH'(xmag);
      d_data_in.crq  = NUM_WIDTH'(c_sc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
         if (en[3]) vld_ff[3] <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_geo_ff <= in_geo;
         a_w1_ff  <= a_w1_in;
         a_w3_ff  <= a_w3_in;
         a_den_ff <= a_den_in;
      end
      if (en[1]) begin
         b_geo_ff <= a_geo_ff;
         b_den_ff <= a_den_ff;
         b_px1_ff <= b_px1_in;
         b_px3_ff <= b_px3_in;
         b_pc1_ff <= b_pc1_in;
         b_pc3_ff <= b_pc3_in;
      end
      if (en[2]) begin
         c_geo_ff <= b_geo_ff;
         c_den_ff <= b_den_ff;
         c_sx_ff  <= c_sx_in;
         c_sc_ff  <= c_sc_in;
      end
      if (en[3]) d_data_ff <= d_data_in;
   end

   assign out_valid = vld_ff[3];
   assign out_data  = d_data_ff;

endmodule

// ===== rtl/tfss_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, x and color lanes.
// Depends on tfss_pkg; fed by tfss_interp, feeds tfss_emit.
module tfss_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tfss_pkg::div_work_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tfss_pkg::div_work_type out_data
);
   import tfss_pkg::*;

   function automatic logic [NUM_WIDTH-1:0] div_step(input logic [NUM_WIDTH-1:0] rq,
                                                      input logic [COORD_WIDTH-1:0] den);
      logic [COORD_WIDTH:0] t;
      logic [COORD_WIDTH:0] d;
      logic                 ge;
      t  = rq[NUM_WIDTH-1:DIV_STEPS-1];
      d  = t - {1'b0, den};
      ge = (t >= {1'b0, den});
      return {ge ? d[COORD_WIDTH-1:0] : t[COORD_WIDTH-1:0], rq[DIV_STEPS-2:0], ge};
   endfunction

   logic [DIV_STEPS-1:0] vld_ff;
   logic [DIV_STEPS:0]   en;
   div_work_type         st_ff [DIV_STEPS];

   assign en[DIV_STEPS] = out_ready;
   assign in_ready      = en[0];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      div_work_type src;
      div_work_type nxt;
      logic         src_vld;

      if (i == 0) begin : g_head
         assign src     = in_data;
         assign src_vld = in_valid;
      end else begin : g_body
         assign src     = st_ff[i-1];
         assign src_vld = vld_ff[i-1];
      end

      assign en[i] = !vld_ff[i] || en[i+1];

      always_comb begin
         nxt     = src;
         nxt.xrq = div_step(src.xrq, src.den);
         nxt.crq = div_step(src.crq, src.den);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en[i]) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) st_ff[i] <= nxt;
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_data  = st_ff[DIV_STEPS-1];

endmodule

// ===== rtl/tfss_emit.sv =====
`timescale 1ns / 1ps
// Output register: holds one setup result and hands out one or two flat triangles, or none for a degenerate one.
// Depends on tfss_pkg; fed by tfss_div.
module tfss_emit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  tfss_pkg::div_work_type                     in_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0]    rsp_apex_x,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0]    rsp_apex_y,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0]    rsp_base_first_x,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0]    rsp_base_y,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0]    rsp_base_second_x,
   output logic        [tfss_pkg::COLOR_WIDTH-1:0]    rsp_apex_color,
   output logic        [tfss_pkg::COLOR_WIDTH-1:0]    rsp_base_first_color,
   output logic        [tfss_pkg::COLOR_WIDTH-1:0]    rsp_base_second_color,
   output logic                                       rsp_last
);
   import tfss_pkg::*;

   logic                   vld_ff;
   logic                   split_ff;
   logic                   phase_ff;
   geo_type                geo_ff;
   logic [COORD_WIDTH-1:0] xa_ff, xa_in;
   logic [COLOR_WIDTH-1:0] ca_ff;
   logic [DIV_STEPS-1:0]   xq;
   logic                   load;
   logic                   take;

   assign take     = vld_ff && rsp_ready;
   assign in_ready = !vld_ff || (rsp_ready && (phase_ff || !split_ff));
   assign load     = in_valid && in_ready;

   // restore the sign of the x cut, truncated toward zero
   always_comb begin
      xq    = in_data.xrq[DIV_STEPS-1:0];
      xa_in = in_data.xneg ? COORD_WIDTH'(-xq) : COORD_WIDTH'(xq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         phase_ff <= 1'b0;
         split_ff <= 1'b0;
      end else if (load) begin
         vld_ff   <= !in_data.geo.drop;
         split_ff <= !in_data.geo.flat_top && !in_data.geo.flat_bot;
         phase_ff <= 1'b0;
      end else if (take) begin
         if (split_ff && !phase_ff) begin
            phase_ff <= 1'b1;
         end else begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         geo_ff <= in_data.geo;
         xa_ff  <= xa_in;
         ca_ff  <= in_data.crq[COLOR_WIDTH-1:0];
      end
   end

   always_comb begin
      rsp_valid = vld_ff;
      if (split_ff && !phase_ff) begin
         rsp_apex_x            = geo_ff.p1.x;
         rsp_apex_y            = geo_ff.p1.y;
         rsp_base_first_x      = xa_ff;
         rsp_base_y            = geo_ff.p2.y;
         rsp_base_second_x     = geo_ff.p2.x;
         rsp_apex_color        = geo_ff.p1.c;
         rsp_base_first_color  = ca_ff;
         rsp_base_second_color = geo_ff.p2.c;
         rsp_last              = 1'b0;
      end else if (split_ff) begin
         rsp_apex_x            = geo_ff.p3.x;
         rsp_apex_y            = geo_ff.p3.y;
         rsp_base_first_x      = geo_ff.p2.x;
         rsp_base_y            = geo_ff.p2.y;
         rsp_base_second_x     = xa_ff;
         rsp_apex_color        = geo_ff.p3.c;
         rsp_base_first_color  = geo_ff.p2.c;
         rsp_base_second_color = ca_ff;
         rsp_last              = 1'b1;
      end else if (geo_ff.flat_top) begin
         rsp_apex_x            = geo_ff.p3.x;
         rsp_apex_y            = geo_ff.p3.y;
         rsp_base_first_x      = geo_ff.p1.x;
         rsp_base_y            = geo_ff.p1.y;
         rsp_base_second_x     = geo_ff.p2.x;
         rsp_apex_color        = geo_ff.p3.c;
         rsp_base_first_color  = geo_ff.p1.c;
         rsp_base_second_color = geo_ff.p2.c;
         rsp_last              = 1'b1;
      end else begin
         rsp_apex_x            = geo_ff.p1.x;
         rsp_apex_y            = geo_ff.p1.y;
         rsp_base_first_x      = geo_ff.p2.x;
         rsp_base_y            = geo_ff.p2.y;
         rsp_base_second_x     = geo_ff.p3.x;
         rsp_apex_color        = geo_ff.p1.c;
         rsp_base_first_color  = geo_ff.p2.c;
         rsp_base_second_color = geo_ff.p3.c;
         rsp_last              = 1'b1;
      end
   end

endmodule

// ===== rtl/triangle_flat_split_setup.sv =====
`timescale 1ns / 1ps
// Top level of the flat-triangle split setup: sort, interpolation setup,
// divider and output register. Depends on tfss_pkg and all tfss_* modules.
//
// Usage:
//   req_* carries one triangle (three signed vertices, one color each) under
//   req_valid/req_ready. rsp_* carries flat triangles under rsp_valid/rsp_ready;
//   rsp_last marks the final one of a triangle. A degenerate triangle (all y
//   equal or all x equal) gives no item; one with a horizontal edge gives one,
//   any other gives two, the cut on the long edge first.
//   From acceptance to the first result item a triangle passes 2 sort
//   stages, 4 setup stages, one divider stage per quotient bit, 16 here, and
//   the output register.
//   Throughput: one triangle per cycle while each gives at most one item and
//   the receiver takes every item; a split triangle holds the single output
//   register until its second item is taken; the next can enter no sooner.
//   Reset clears all valid bits; nothing else needs clearing.
//   When the receiver stalls, the output register holds its item and the
//   stages behind it fill up, empty stages first; req_ready falls only once
//   every stage is occupied. No item is lost or repeated.
module triangle_flat_split_setup (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [tfss_pkg::COORD_WIDTH-1:0] req_ax,
   input  logic signed [tfss_pkg::COORD_WIDTH-1:0] req_ay,
   input  logic signed [tfss_pkg::COORD_WIDTH-1:0] req_bx,
   input  logic signed [tfss_pkg::COORD_WIDTH-1:0] req_by,
   input  logic signed [tfss_pkg::COORD_WIDTH-1:0] req_cx,
   input  logic signed [tfss_pkg::COORD_WIDTH-1:0] req_cy,
   input  logic        [tfss_pkg::COLOR_WIDTH-1:0] req_a_color,
   input  logic        [tfss_pkg::COLOR_WIDTH-1:0] req_b_color,
   input  logic        [tfss_pkg::COLOR_WIDTH-1:0] req_c_color,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0] rsp_apex_x,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0] rsp_apex_y,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0] rsp_base_first_x,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0] rsp_base_y,
   output logic signed [tfss_pkg::COORD_WIDTH-1:0] rsp_base_second_x,
   output logic        [tfss_pkg::COLOR_WIDTH-1:0] rsp_apex_color,
   output logic        [tfss_pkg::COLOR_WIDTH-1:0] rsp_base_first_color,
   output logic        [tfss_pkg::COLOR_WIDTH-1:0] rsp_base_second_color,
   output logic                                    rsp_last
);
   import tfss_pkg::*;

   vtx_type      va, vb, vc;
   logic         srt_valid, srt_ready;
   geo_type      srt_geo;
   logic         itp_valid, itp_ready;
   div_work_type itp_data;
   logic         div_valid, div_ready;
   div_work_type div_data;

   always_comb begin
      va.x = req_ax;
      va.y = req_ay;
      va.c = req_a_color;
      vb.x = req_bx;
      vb.y = req_by;
      vb.c = req_b_color;
      vc.x = req_cx;
      vc.y = req_cy;
      vc.c = req_c_color;
   end

   tfss_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_a      (va),
      .in_b      (vb),
      .in_c      (vc),
      .out_valid (srt_valid),
      .out_ready (srt_ready),
      .out_geo   (srt_geo)
   );

   tfss_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (srt_valid),
      .in_ready  (srt_ready),
      .in_geo    (srt_geo),
      .out_valid (itp_valid),
      .out_ready (itp_ready),
      .out_data  (itp_data)
   );

   tfss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (itp_valid),
      .in_ready  (itp_ready),
      .in_data   (itp_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   tfss_emit u_emit (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (div_valid),
      .in_ready              (div_ready),
      .in_data               (div_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_apex_x            (rsp_apex_x),
      .rsp_apex_y            (rsp_apex_y),
      .rsp_base_first_x      (rsp_base_first_x),
      .rsp_base_y            (rsp_base_y),
      .rsp_base_second_x     (rsp_base_second_x),
      .rsp_apex_color        (rsp_apex_color),
      .rsp_base_first_color  (rsp_base_first_color),
      .rsp_base_second_color (rsp_base_second_color),
      .rsp_last              (rsp_last)
   );

endmodule
